/* rtl/cbf_pkg.sv */
// cbf_pkg: shared types, constants and weight functions of the bezier flattener
// used by every module of the block, depends on nothing
`default_nettype none

package cbf_pkg;

  localparam int STEPS     = 32;
  localparam int STEP_W    = $clog2(STEPS);
  localparam int COORD_W   = 32;
  localparam int TOL_W     = 16;
  localparam int WGT_W     = 16;
  localparam int PROD_W    = 48;
  localparam int FRAC_SH   = $clog2(STEPS * STEPS * STEPS);
  localparam int QDEPTH    = 2;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'((STEPS * STEPS * STEPS) / 2);
  localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(1);
  localparam logic              TOL_REG_IDX = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] out_handle_x;
    logic signed [COORD_W-1:0] out_handle_y;
    logic signed [COORD_W-1:0] in_handle_x;
    logic signed [COORD_W-1:0] in_handle_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      append_end;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last;
  } result_t;

  typedef struct packed {
    item_t seg;
    logic  linear;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CURVE,
    ST_END
  } state_t;

  typedef enum logic [1:0] {
    PT_CURVE,
    PT_START,
    PT_END
  } point_sel_t;

  typedef struct packed {
    logic              valid;
    point_sel_t        sel;
    logic [STEP_W-1:0] k;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [WGT_W-1:0] w0;
    logic [WGT_W-1:0] w1;
    logic [WGT_W-1:0] w2;
    logic [WGT_W-1:0] w3;
  } weights_t;

  // bernstein weights scaled by STEPS cubed
  function automatic weights_t bez_weights(logic [STEP_W-1:0] k);
    int       j;
    int       r;
    weights_t w;
    j = int'(k);
    r = STEPS - j;
    w.w0 = WGT_W'(r * r * r);
    w.w1 = WGT_W'(3 * r * r * j);
    w.w2 = WGT_W'(3 * r * j * j);
    w.w3 = WGT_W'(j * j * j);
    return w;
  endfunction

  function automatic logic signed [PROD_W-1:0] wmul(logic signed [COORD_W-1:0] c,
                                                   logic [WGT_W-1:0] w);
    logic signed [PROD_W-1:0] ce;
    logic signed [PROD_W-1:0] we;
    ce = PROD_W'(c);
    we = PROD_W'($signed({1'b0, w}));
    return ce * we;
  endfunction

  function automatic logic near_eq(logic signed [COORD_W-1:0] a,
                                   logic signed [COORD_W-1:0] b,
                                   logic [TOL_W-1:0] tol);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        mag;
    d   = (COORD_W+1)'(a) - (COORD_W+1)'(b);
    mag = d[COORD_W] ? (COORD_W+1)'(-d) : (COORD_W+1)'(d);
    return mag < (COORD_W+1)'(tol);
  endfunction

endpackage

`default_nettype wire

/* rtl/cbf_front.sv */
// cbf_front: accepts segments and classifies them as linear or curved
// depends on cbf_pkg
`default_nettype none

module cbf_front
  import cbf_pkg::*;
(
  input  wire logic             seg_valid,
  output logic                  seg_ready,
  input  wire item_t            seg,
  input  wire logic [TOL_W-1:0] tol,
  input  wire logic             q_full,
  output logic                  push,
  output entry_t                push_entry
);

  logic start_on;
  logic end_on;

  assign start_on = near_eq(seg.start_x, seg.out_handle_x, tol)
                  && near_eq(seg.start_y, seg.out_handle_y, tol);
  assign end_on   = near_eq(seg.in_handle_x, seg.end_x, tol)
                  && near_eq(seg.in_handle_y, seg.end_y, tol);

  assign seg_ready         = !q_full;
  assign push              = seg_valid && !q_full;
  assign push_entry.seg    = seg;
  assign push_entry.linear = start_on && end_on;

endmodule

`default_nettype wire

/* rtl/cbf_queue.sv */
// cbf_queue: short queue of classified segments between front and back
// depends on cbf_pkg
`default_nettype none

module cbf_queue
  import cbf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        head_valid,
  output entry_t      head
);

  localparam int PTR_W = $clog2(QDEPTH);

  entry_t            slots [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QDEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count != QCNT_W'(QDEPTH))
    else $error("queue pushed while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count != '0)
    else $error("queue count lost an entry");

endmodule

`default_nettype wire

/* rtl/cbf_seq.sv */
// cbf_seq: back-end sequencer, walks the queue head and issues point commands
// depends on cbf_pkg
`default_nettype none

module cbf_seq
  import cbf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  wire entry_t head,
  input  wire logic   adv,
  output cmd_t        cmd,
  output logic        pop
);

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (adv && head_valid) begin
          if (head.linear) begin
            if (head.seg.append_end) begin
              state_next = ST_END;
            end
          end else begin
            state_next = ST_CURVE;
            step_next  = STEP_W'(1);
          end
        end
      end
      ST_CURVE: begin
        if (adv) begin
          if (step == LAST_STEP) begin
            step_next  = '0;
            state_next = head.seg.append_end ? ST_END : ST_IDLE;
          end else begin
            step_next = STEP_W'(step + 1'b1);
          end
        end
      end
      ST_END: begin
        if (adv) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_comb begin
    cmd.valid = 1'b0;
    cmd.sel   = PT_CURVE;
    cmd.k     = '0;
    cmd.last  = 1'b0;
    pop       = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.valid = head_valid;
        cmd.sel   = head.linear ? PT_START : PT_CURVE;
        cmd.last  = head.linear && !head.seg.append_end;
        pop       = adv && head_valid && head.linear && !head.seg.append_end;
      end
      ST_CURVE: begin
        cmd.valid = 1'b1;
        cmd.k     = step;
        cmd.last  = (step == LAST_STEP) && !head.seg.append_end;
        pop       = adv && (step == LAST_STEP) && !head.seg.append_end;
      end
      ST_END: begin
        cmd.valid = 1'b1;
        cmd.sel   = PT_END;
        cmd.last  = 1'b1;
        pop       = adv;
      end
      default: begin
        cmd.valid = 1'b0;
      end
    endcase
  end

  a_curve_has_head: assert property (@(posedge clk) disable iff (rst)
    state == ST_CURVE || state == ST_END |-> head_valid)
    else $error("sequencer running without a queued segment");

  a_end_needs_append: assert property (@(posedge clk) disable iff (rst)
    state == ST_END |-> head.seg.append_end)
    else $error("end point issued for a closed segment");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |-> cmd.valid && cmd.last && adv)
    else $error("segment retired before its last point");

  a_curve_not_linear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CURVE |-> !head.linear)
    else $error("linear segment expanded as a curve");

endmodule

`default_nettype wire

/* rtl/cbf_datapath.sv */
// cbf_datapath: bernstein evaluation pipeline, products, pair sums, rounding
// depends on cbf_pkg
`default_nettype none

module cbf_datapath
  import cbf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cmd_t    cmd,
  input  wire entry_t  head,
  output logic         adv,
  output logic         pt_valid,
  input  wire logic    pt_ready,
  output result_t      pt
);

  typedef struct packed {
    logic byp;
    logic last;
  } stage_ctl_t;

  weights_t                  w;
  logic                      s1_valid;
  logic                      s2_valid;
  stage_ctl_t                s1_ctl;
  stage_ctl_t                s2_ctl;
  logic signed [PROD_W-1:0]  s1_px [4];
  logic signed [PROD_W-1:0]  s1_py [4];
  logic signed [COORD_W-1:0] s1_bx;
  logic signed [COORD_W-1:0] s1_by;
  logic signed [PROD_W-1:0]  s2_ax;
  logic signed [PROD_W-1:0]  s2_cx;
  logic signed [PROD_W-1:0]  s2_ay;
  logic signed [PROD_W-1:0]  s2_cy;
  logic signed [COORD_W-1:0] s2_bx;
  logic signed [COORD_W-1:0] s2_by;
  logic signed [PROD_W-1:0]  sum_x;
  logic signed [PROD_W-1:0]  sum_y;

  assign adv   = !pt_valid || pt_ready;
  assign w     = bez_weights(cmd.k);
  assign sum_x = s2_ax + s2_cx;
  assign sum_y = s2_ay + s2_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      pt_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cmd.valid;
      s2_valid <= s1_valid;
      pt_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl.byp  <= cmd.sel != PT_CURVE;
      s1_ctl.last <= cmd.last;
      s1_bx       <= (cmd.sel == PT_END) ? head.seg.end_x : head.seg.start_x;
      s1_by       <= (cmd.sel == PT_END) ? head.seg.end_y : head.seg.start_y;
      s1_px[0]    <= wmul(head.seg.start_x, w.w0);
      s1_px[1]    <= wmul(head.seg.out_handle_x, w.w1);
      s1_px[2]    <= wmul(head.seg.in_handle_x, w.w2);
      s1_px[3]    <= wmul(head.seg.end_x, w.w3);
      s1_py[0]    <= wmul(head.seg.start_y, w.w0);
      s1_py[1]    <= wmul(head.seg.out_handle_y, w.w1);
      s1_py[2]    <= wmul(head.seg.in_handle_y, w.w2);
      s1_py[3]    <= wmul(head.seg.end_y, w.w3);

      s2_ctl.byp  <= s1_ctl.byp;
      s2_ctl.last <= s1_ctl.last;
      s2_bx       <= s1_bx;
      s2_by       <= s1_by;
      s2_ax       <= s1_px[0] + s1_px[1];
      s2_cx       <= s1_px[2] + s1_px[3] + $signed(ROUND_HALF);
      s2_ay       <= s1_py[0] + s1_py[1];
      s2_cy       <= s1_py[2] + s1_py[3] + $signed(ROUND_HALF);

      // floor after adding half: take the bits above the scale
      pt.point_x  <= s2_ctl.byp ? s2_bx : sum_x[FRAC_SH +: COORD_W];
      pt.point_y  <= s2_ctl.byp ? s2_by : sum_y[FRAC_SH +: COORD_W];
      pt.last     <= s2_ctl.last;
    end
  end

endmodule

`default_nettype wire

/* rtl/cubic_bezier_flattener_unit.sv */
// cubic_bezier_flattener_unit: top level, config register and block wiring
// depends on cbf_pkg, cbf_front, cbf_queue, cbf_seq, cbf_datapath
//
// usage: one cubic segment (start, two handles, end, append_end) is offered
// on seg_valid/seg_ready/seg; polyline points leave on pt_valid/pt_ready/pt,
// the last point of each segment's run carrying last
// a segment whose handles sit on their anchors (within linear_tolerance on
// each axis) gives its start point only; any other gives 32 points at
// t = k/32; append_end adds the end point after either run
// the front classifies a segment in the cycle it is accepted and queues it
// (two entries); the back walks the queue head and, unless stalled, issues
// one point a cycle into a three-stage evaluation pipeline (products, pair
// sums, rounding); a queued segment's points pass s1, s2 and pt in order
// throughput: one point per cycle while pt_ready is high; a curved
// segment gives 32 or 33 points, a linear one 1 or 2
// a stall on pt_ready freezes the whole back; the front keeps accepting until
// the queue is full
// reset: queue and pipeline empty, linear_tolerance at 1
// register 0 (byte address 0): linear_tolerance, 16 bits
`default_nettype none

module cubic_bezier_flattener_unit
  import cbf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              seg_valid,
  output logic                   seg_ready,
  input  wire item_t             seg,
  output logic                   pt_valid,
  input  wire logic              pt_ready,
  output result_t                pt,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [TOL_W-1:0] tol;
  logic             q_full;
  logic             push;
  entry_t           push_entry;
  logic             pop;
  logic             head_valid;
  entry_t           head;
  logic             adv;
  cmd_t             cmd;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[ADDR_W-1] == TOL_REG_IDX;
  assign prdata  = reg_hit ? DATA_W'(tol) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      tol <= pwdata[TOL_W-1:0];
    end
  end

  cbf_front u_front (
    .seg_valid  (seg_valid),
    .seg_ready  (seg_ready),
    .seg        (seg),
    .tol        (tol),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  cbf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  cbf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .adv        (adv),
    .cmd        (cmd),
    .pop        (pop)
  );

  cbf_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .head     (head),
    .adv      (adv),
    .pt_valid (pt_valid),
    .pt_ready (pt_ready),
    .pt       (pt)
  );

endmodule

`default_nettype wire

/* tb/sv/cubic_bezier_flattener_unit_tb.sv */
// cubic_bezier_flattener_unit_tb: self-checking bench for the bezier flattener
// offers segments and apb register writes, predicts every polyline point
// depends on cbf_pkg and cubic_bezier_flattener_unit
module cubic_bezier_flattener_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbf_pkg::*;

  localparam int DIR_ROWS      = 21;
  localparam int RANDOM_BLOCKS = 6;
  localparam int BLOCK_ITEMS   = 66;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;
  localparam int SPARSE_IDLE   = 13;
  localparam int HEAVY_IDLE    = 77;

  localparam int unsigned REG_TOL    = 0;
  localparam int unsigned REG_UNUSED = 1;

  localparam int CMIN = 32'sh8000_0000;
  localparam int CMAX = 32'sh7fff_ffff;

  localparam longint CURVE_STEPS = STEPS;

  typedef enum logic [1:0] {
    ROW_SEG,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    item_t             seg;
    logic [7:0]        reg_index;
    logic [DATA_W-1:0] data;
    logic [1:0]        n_typed;
    result_t           exp0;
    result_t           exp1;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              seg_valid = 1'b0;
  logic              seg_ready;
  item_t             seg = '0;
  logic              pt_valid;
  logic              pt_ready = 1'b0;
  result_t           pt;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [TOL_W-1:0] tol_setting = TOL_RESET;
  result_t          expected_points[$];
  int               mismatches = 0;
  int               stall_cycles = 0;
  int               src_idle_pct = SPARSE_IDLE;
  int               dst_idle_pct = HEAVY_IDLE;
  dir_row_t         dir_table[DIR_ROWS];

  cubic_bezier_flattener_unit uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void add_expected(result_t p);
    expected_points.insert(expected_points.size(), p);
  endfunction

  function automatic dir_row_t seg_row(int sx, int sy, int ox, int oy, int ix, int iy,
                                       int ex, int ey, bit app, int n_typed = 0,
                                       result_t e0 = '0, result_t e1 = '0);
    dir_row_t r;
    r = '0;
    r.kind = ROW_SEG;
    r.seg.start_x = sx;
    r.seg.start_y = sy;
    r.seg.out_handle_x = ox;
    r.seg.out_handle_y = oy;
    r.seg.in_handle_x = ix;
    r.seg.in_handle_y = iy;
    r.seg.end_x = ex;
    r.seg.end_y = ey;
    r.seg.append_end = app;
    r.n_typed = 2'(n_typed);
    r.exp0 = e0;
    r.exp1 = e1;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(int unsigned index, logic [DATA_W-1:0] value);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_index = 8'(index);
    r.data = value;
    return r;
  endfunction

  function automatic logic near_anchor(logic signed [COORD_W-1:0] a,
                                       logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d < longint'(tol_setting);
  endfunction

  function automatic logic signed [COORD_W-1:0] curve_coord(logic signed [COORD_W-1:0] p0,
                                                            logic signed [COORD_W-1:0] p1,
                                                            logic signed [COORD_W-1:0] p2,
                                                            logic signed [COORD_W-1:0] p3,
                                                            longint k);
    longint r;
    longint den;
    longint sum;
    longint q;
    r = CURVE_STEPS - k;
    den = CURVE_STEPS * CURVE_STEPS * CURVE_STEPS;
    sum = r * r * r * p0 + 3 * r * r * k * p1 + 3 * r * k * k * p2 + k * k * k * p3;
    sum = sum + den / 2;
    q = sum / den;
    if ((sum % den) != 0 && sum < 0) q = q - 1;
    return q[COORD_W-1:0];
  endfunction

  function automatic void flatten_segment(item_t s);
    logic    lin;
    result_t p;
    lin = near_anchor(s.start_x, s.out_handle_x) && near_anchor(s.start_y, s.out_handle_y)
       && near_anchor(s.in_handle_x, s.end_x) && near_anchor(s.in_handle_y, s.end_y);
    if (lin) begin
      p.point_x = s.start_x;
      p.point_y = s.start_y;
      p.last = !s.append_end;
      add_expected(p);
    end else begin
      for (int k = 0; k < STEPS; k++) begin
        p.point_x = curve_coord(s.start_x, s.out_handle_x, s.in_handle_x, s.end_x, k);
        p.point_y = curve_coord(s.start_y, s.out_handle_y, s.in_handle_y, s.end_y, k);
        p.last = (k == STEPS - 1) && !s.append_end;
        add_expected(p);
      end
    end
    if (s.append_end) begin
      p.point_x = s.end_x;
      p.point_y = s.end_y;
      p.last = 1'b1;
      add_expected(p);
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return CMIN;
      1: return CMAX;
      2: return $urandom_range(2097152) - 1048576;
      default: return $urandom;
    endcase
  endfunction

  // move a coordinate by mag either way, reflecting back inside the range
  function automatic logic signed [COORD_W-1:0] shift_coord(logic signed [COORD_W-1:0] a,
                                                            longint mag);
    longint b;
    b = $urandom_range(1) ? longint'(a) + mag : longint'(a) - mag;
    if (b > CMAX || b < CMIN) b = 2 * longint'(a) - b;
    return b[COORD_W-1:0];
  endfunction

  function automatic item_t random_segment();
    item_t       s;
    int unsigned mode;
    longint      lim;
    s.start_x = rand_coord();
    s.start_y = rand_coord();
    s.out_handle_x = rand_coord();
    s.out_handle_y = rand_coord();
    s.in_handle_x = rand_coord();
    s.in_handle_y = rand_coord();
    s.end_x = rand_coord();
    s.end_y = rand_coord();
    s.append_end = 1'($urandom_range(1));
    mode = $urandom_range(9);
    lim = longint'(tol_setting);
    if (mode <= 3 && tol_setting != 0) begin
      s.out_handle_x = shift_coord(s.start_x, $urandom_range(32'(lim - 1)));
      s.out_handle_y = shift_coord(s.start_y, $urandom_range(32'(lim - 1)));
      s.in_handle_x = shift_coord(s.end_x, $urandom_range(32'(lim - 1)));
      s.in_handle_y = shift_coord(s.end_y, $urandom_range(32'(lim - 1)));
      // one handle exactly at the tolerance, just curved
      if (mode == 3) begin
        case ($urandom_range(3))
          0: s.out_handle_x = shift_coord(s.start_x, lim);
          1: s.out_handle_y = shift_coord(s.start_y, lim);
          2: s.in_handle_x = shift_coord(s.end_x, lim);
          default: s.in_handle_y = shift_coord(s.end_y, lim);
        endcase
      end
    end
    return s;
  endfunction

  task automatic send_segment(item_t s, int n_typed, result_t e0, result_t e1);
    while ($urandom_range(99) < src_idle_pct) begin
      seg_valid <= 1'b0;
      @(posedge clk);
    end
    seg_valid <= 1'b1;
    seg <= s;
    @(posedge clk);
    while (!seg_ready) @(posedge clk);
    if (n_typed == 0) begin
      flatten_segment(s);
    end else begin
      add_expected(e0);
      if (n_typed > 1) add_expected(e1);
    end
  endtask

  task automatic drain();
    seg_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(int unsigned index, logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * index);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_TOL) tol_setting = value[TOL_W-1:0];
  endtask

  always @(posedge clk) begin : point_check
    result_t want;
    if (!rst && pt_valid && pt_ready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected point x=%0d y=%0d last=%0b", pt.point_x, pt.point_y, pt.last);
      end else begin
        want = expected_points.pop_front();
        if (pt.point_x !== want.point_x || pt.point_y !== want.point_y
            || pt.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("point mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     want.point_x, want.point_y, want.last, pt.point_x, pt.point_y, pt.last);
        end
      end
    end
    pt_ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (seg_valid && seg_ready) || (pt_valid && pt_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [DATA_W-1:0] tol_plan;
    dir_table = '{
      seg_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1, '{0, 0, 1'b1}),
      seg_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 2, '{0, 0, 1'b0}, '{0, 0, 1'b1}),
      seg_row(CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, 1'b1, 2,
              '{CMAX, CMIN, 1'b0}, '{CMIN, CMAX, 1'b1}),
      seg_row(CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, 1'b0, 1, '{CMIN, CMAX, 1'b1}),
      seg_row(0, 0, 1, 0, 0, 0, 0, 0, 1'b0),
      seg_row(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 1'b1),
      seg_row(CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, 1'b0),
      seg_row(0, 0, 10 * 65536, 20 * 65536, 30 * 65536, -5 * 65536, 40 * 65536, 0, 1'b1),
      cfg_row(REG_UNUSED, 0),
      seg_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1, '{0, 0, 1'b1}),
      cfg_row(REG_TOL, 0),
      seg_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b0),
      seg_row(5, -7, 5, -7, 9, 3, 9, 3, 1'b1),
      cfg_row(REG_TOL, 65535),
      seg_row(0, 0, 65534, -65534, -64534, 64534, 1000, -1000, 1'b0, 1, '{0, 0, 1'b1}),
      seg_row(0, 0, 65535, -65534, -64534, 64534, 1000, -1000, 1'b1),
      seg_row(CMIN, 0, CMAX, 0, 0, 0, 0, 0, 1'b0),
      cfg_row(REG_TOL, 32'hffff_0005),
      seg_row(100, 100, 104, 96, 200, -200, 200, -200, 1'b1, 2,
              '{100, 100, 1'b0}, '{200, -200, 1'b1}),
      seg_row(100, 100, 105, 96, 200, -200, 200, -200, 1'b0),
      seg_row(100, 100, 100, 100, 200, -195, 200, -200, 1'b1)
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        drain();
        write_register(dir_table[i].reg_index, dir_table[i].data);
      end else begin
        send_segment(dir_table[i].seg, dir_table[i].n_typed, dir_table[i].exp0,
                     dir_table[i].exp1);
      end
    end
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      drain();
      case (blk)
        0: tol_plan = 1;
        1: tol_plan = 0;
        2: tol_plan = 65535;
        3: tol_plan = $urandom_range(300, 2);
        4: tol_plan = $urandom_range(65535);
        default: tol_plan = $urandom_range(40, 1);
      endcase
      write_register(REG_TOL, tol_plan);
      src_idle_pct = (blk < 2) ? SPARSE_IDLE : (blk < 4) ? HEAVY_IDLE : 0;
      dst_idle_pct = (blk < 2) ? HEAVY_IDLE : (blk < 4) ? SPARSE_IDLE : 0;
      repeat (BLOCK_ITEMS) send_segment(random_segment(), 0, '0, '0);
    end
    drain();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
